FILE: src/mrac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_pkg
// Shared types, widths and codes of the memory region allocate/check core.
// ----------------------------------------------------------------------------
package mrac_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int PID_W   = 4;
    localparam int ADDR_W  = 32;
    localparam int END_W   = ADDR_W + 1;
    localparam int STAT_W  = 3;

    // Parameter defaults
    localparam int REGION_COUNT_DEF  = 16;
    localparam int PROCESS_COUNT_DEF = 16;

    // Reset value of the memory limit register
    localparam logic [ADDR_W-1:0] MEM_AVAILABLE_RESET = 32'd1048576;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCESS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BEYOND  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERLAP = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd4;

    // One table entry as stored in the region RAM
    typedef struct packed {
        logic [PID_W-1:0]  owner;
        logic [END_W-1:0]  upper;
        logic [ADDR_W-1:0] lower;
    } region_entry_t;

    localparam int ENTRY_W = $bits(region_entry_t);

    // Result of comparing the current item against one entry
    typedef struct packed {
        logic overlap;    // touches or overlaps the entry
        logic contained;  // lies within the entry
        logic owned;      // entry belongs to the requesting process
    } cmp_flags_t;

endpackage : mrac_pkg
`default_nettype wire

FILE: src/mrac_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_if
// Valid/ready channels of the region core: request, response, config write.
// ----------------------------------------------------------------------------

// Request channel
interface mrac_req_if
    import mrac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PID_W-1:0]  process_id;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;

    modport source (output valid, command, process_id, base, size, input ready);
    modport sink   (input valid, command, process_id, base, size, output ready);
endinterface : mrac_req_if

// Response channel
interface mrac_rsp_if
    import mrac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              granted;
    logic [STAT_W-1:0] status;

    modport source (output valid, granted, status, input ready);
    modport sink   (input valid, granted, status, output ready);
endinterface : mrac_rsp_if

// Configuration write channel (memory limit register)
interface mrac_cfg_if
    import mrac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface : mrac_cfg_if
`default_nettype wire

FILE: src/mrac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mrac_ram
`default_nettype wire

FILE: src/mrac_region_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_region_cmp
// Shared compare unit: tests the item's range against one table entry.
// ----------------------------------------------------------------------------
module mrac_region_cmp
    import mrac_pkg::*;
(
    input  wire region_entry_t     entry,
    input  wire logic [ADDR_W-1:0] lo,
    input  wire logic [END_W-1:0]  hi,
    input  wire logic [PID_W-1:0]  pid,
    output cmp_flags_t             flags
);

    logic [END_W-1:0] lo_ext;
    logic [END_W-1:0] lower_ext;

    assign lo_ext    = {1'b0, lo};
    assign lower_ext = {1'b0, entry.lower};

    // Touching end points count as overlap
    assign flags.overlap   = (lo_ext <= entry.upper) && (hi >= lower_ext);
    assign flags.contained = (lo_ext >= lower_ext) && (hi <= entry.upper);
    assign flags.owned     = (entry.owner == pid);

endmodule : mrac_region_cmp
`default_nettype wire

FILE: src/memory_region_allocate_and_check_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_region_allocate_and_check_core
// Region table that allocates, checks and releases memory regions per process.
// ----------------------------------------------------------------------------
// Usage:
//   req  : command, process_id, base, size; taken when valid and ready are high.
//   rsp  : one item (granted, status) for every request item.
//   cfg  : writes the memory limit; always ready, write only while idle.
// Scan:
//   A request scans the table through one RAM read port and one compare unit,
//   one entry per cycle. A granted allocation scans the whole table and then
//   writes the new entry; any other full scan ends without a write. A limit
//   refusal or an unknown command or process skips the scan, a matching
//   access or an overlap stops the scan early. One request is in work at a
//   time; req.ready is high only while the sequencer is idle.
// Reset:
//   All region valid bits clear at once, the limit returns to 1048576, no
//   clearing pass is needed.
// Stalls:
//   A result waits in the output register; the next request may be taken
//   meanwhile, and its result is held back until the waiting one is taken.
// ----------------------------------------------------------------------------
module memory_region_allocate_and_check_core
    import mrac_pkg::*;
#(
    parameter int REGION_COUNT  = REGION_COUNT_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mrac_cfg_if.sink  cfg,
    mrac_req_if.sink  req,
    mrac_rsp_if.source rsp
);

    localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int CNT_W = $clog2(REGION_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(REGION_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [ADDR_W-1:0]   lo_reg;
    logic [END_W-1:0]    hi_reg;
    logic [ADDR_W-1:0]   mem_avail_reg;
    logic [REGION_COUNT-1:0] valid_reg;
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                slot_found_reg;
    logic [IDX_W-1:0]    slot_idx_reg;
    logic                res_granted_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic                out_valid_reg;
    logic                out_granted_reg;
    logic [STAT_W-1:0]   out_status_reg;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    region_entry_t       wr_entry;
    region_entry_t       rd_entry;
    cmp_flags_t          flags;
    logic                entry_valid;
    logic                last_entry;
    logic                free_here;
    logic                pid_known;

    // Channel handshakes
    assign req.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.granted = out_granted_reg;
    assign rsp.status  = out_status_reg;

    // Table read / write control
    assign rd_en    = (state_reg == S_SCAN) && (issue_cnt_reg < CNT_END);
    assign rd_addr  = issue_cnt_reg[IDX_W-1:0];
    assign wr_en    = (state_reg == S_WRITE);
    assign wr_entry = '{owner: pid_reg, upper: hi_reg, lower: lo_reg};
    assign rd_entry = region_entry_t'(rd_data);

    mrac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (REGION_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_idx_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mrac_region_cmp u_cmp (
        .entry (rd_entry),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .pid   (pid_reg),
        .flags (flags)
    );

    // Per-entry scan conditions
    assign entry_valid = valid_reg[pend_idx_reg];
    assign last_entry  = (pend_idx_reg == LAST_IDX);
    assign free_here   = !entry_valid && !slot_found_reg;
    assign pid_known   = (32'(pid_reg) < PROCESS_COUNT);

    // Memory limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_avail_reg <= MEM_AVAILABLE_RESET;
        end
        else if (cfg.valid)
        begin
            mem_avail_reg <= cfg.data;
        end
    end

    // Sequencer, table valid bits and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_ALLOC;
            pid_reg         <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            valid_reg       <= '0;
            issue_cnt_reg   <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            slot_found_reg  <= 1'b0;
            slot_idx_reg    <= '0;
            res_granted_reg <= 1'b0;
            res_status_reg  <= ST_OK;
            out_valid_reg   <= 1'b0;
            out_granted_reg <= 1'b0;
            out_status_reg  <= ST_OK;
        end
        else
        begin
            // Result taken by the receiver; S_DONE refills the register itself
            if (out_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg   <= req.command;
                        pid_reg   <= req.process_id;
                        lo_reg    <= req.base;
                        hi_reg    <= {1'b0, req.base} + {1'b0, req.size};
                        state_reg <= S_CHECK;
                    end
                end

                // Unknown requests and the memory limit
                S_CHECK:
                begin
                    issue_cnt_reg  <= '0;
                    pend_reg       <= 1'b0;
                    slot_found_reg <= 1'b0;
                    if (!pid_known || cmd_reg == CMD_RESERVED)
                    begin
                        res_granted_reg <= 1'b0;
                        res_status_reg  <= ST_OK;
                        state_reg       <= S_DONE;
                    end
                    else if (cmd_reg == CMD_ALLOC && hi_reg > {1'b0, mem_avail_reg})
                    begin
                        res_granted_reg <= 1'b0;
                        res_status_reg  <= ST_BEYOND;
                        state_reg       <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end

                // One entry issued and one entry compared per cycle
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                        pend_reg      <= 1'b1;
                        pend_idx_reg  <= rd_addr;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end

                    if (pend_reg)
                    begin
                        case (cmd_reg)
                            CMD_ALLOC:
                            begin
                                if (entry_valid && flags.overlap)
                                begin
                                    res_granted_reg <= 1'b0;
                                    res_status_reg  <= ST_OVERLAP;
                                    state_reg       <= S_DONE;
                                end
                                else
                                begin
                                    if (free_here)
                                    begin
                                        slot_found_reg <= 1'b1;
                                        slot_idx_reg   <= pend_idx_reg;
                                    end
                                    if (last_entry)
                                    begin
                                        if (slot_found_reg || free_here)
                                        begin
                                            state_reg <= S_WRITE;
                                        end
                                        else
                                        begin
                                            res_granted_reg <= 1'b0;
                                            res_status_reg  <= ST_FULL;
                                            state_reg       <= S_DONE;
                                        end
                                    end
                                end
                            end

                            CMD_ACCESS:
                            begin
                                if (entry_valid && flags.owned && flags.contained)
                                begin
                                    res_granted_reg <= 1'b1;
                                    res_status_reg  <= ST_OK;
                                    state_reg       <= S_DONE;
                                end
                                else if (last_entry)
                                begin
                                    res_granted_reg <= 1'b0;
                                    res_status_reg  <= ST_OUTSIDE;
                                    state_reg       <= S_DONE;
                                end
                            end

                            CMD_RELEASE:
                            begin
                                if (entry_valid && flags.owned)
                                begin
                                    valid_reg[pend_idx_reg] <= 1'b0;
                                end
                                if (last_entry)
                                begin
                                    res_granted_reg <= 1'b1;
                                    res_status_reg  <= ST_OK;
                                    state_reg       <= S_DONE;
                                end
                            end

                            default:
                            begin
                                res_granted_reg <= 1'b0;
                                res_status_reg  <= ST_OK;
                                state_reg       <= S_DONE;
                            end
                        endcase
                    end
                end

                // New region goes into the lowest free entry
                S_WRITE:
                begin
                    valid_reg[slot_idx_reg] <= 1'b1;
                    res_granted_reg         <= 1'b1;
                    res_status_reg          <= ST_OK;
                    state_reg               <= S_DONE;
                end

                // Hand the result to the output register once it is free
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_granted_reg <= res_granted_reg;
                        out_status_reg  <= res_status_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : memory_region_allocate_and_check_core
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the memory region allocate/check core. A directed
// table walks the edge cases of allocate, access and release. A table fill
// follows, then random traffic in several memory-limit settings. Every
// response item is compared against a cycle-free model of the region table,
// with random idle gaps on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
module testbench;
    import mrac_pkg::*;

    localparam int TABLE_DEPTH   = REGION_COUNT_DEF;
    localparam int MAX_CYCLES    = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DIR_N         = 21;
    localparam int PHASE_N       = 7;

    typedef struct packed {
        logic              granted;
        logic [STAT_W-1:0] status;
    } verdict_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic              typed;
        logic              granted;
        logic [STAT_W-1:0] status;
    } dir_row_t;

    // Directed rows; typed rows carry their own expected verdict
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{CMD_ACCESS,   4'd0,  32'd0,           32'd0,           1'b1, 1'b0, ST_OUTSIDE},
        '{CMD_RELEASE,  4'd5,  32'd0,           32'd0,           1'b1, 1'b1, ST_OK},
        '{CMD_RESERVED, 4'd15, 32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 1'b0, ST_OK},
        '{CMD_ALLOC,    4'd1,  32'd0,           32'hFFFF_FFFF,   1'b1, 1'b0, ST_BEYOND},
        '{CMD_ALLOC,    4'd1,  32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 1'b0, ST_BEYOND},
        '{CMD_ALLOC,    4'd15, 32'hFFFF_FFFF,   32'd0,           1'b1, 1'b0, ST_BEYOND},
        '{CMD_ALLOC,    4'd1,  32'd0,           32'd1048576,     1'b1, 1'b1, ST_OK},
        '{CMD_ACCESS,   4'd1,  32'd0,           32'd1048576,     1'b1, 1'b1, ST_OK},
        '{CMD_ACCESS,   4'd2,  32'd0,           32'd0,           1'b1, 1'b0, ST_OUTSIDE},
        '{CMD_ALLOC,    4'd2,  32'd1048576,     32'd0,           1'b1, 1'b0, ST_OVERLAP},
        '{CMD_RELEASE,  4'd1,  32'd0,           32'd0,           1'b1, 1'b1, ST_OK},
        '{CMD_ACCESS,   4'd1,  32'd0,           32'd0,           1'b1, 1'b0, ST_OUTSIDE},
        '{CMD_ALLOC,    4'd2,  32'd100,         32'd0,           1'b1, 1'b1, ST_OK},
        '{CMD_ALLOC,    4'd3,  32'd100,         32'd0,           1'b1, 1'b0, ST_OVERLAP},
        '{CMD_ALLOC,    4'd3,  32'd90,          32'd10,          1'b1, 1'b0, ST_OVERLAP},
        '{CMD_ALLOC,    4'd3,  32'd101,         32'd9,           1'b0, 1'b0, ST_OK},
        '{CMD_ACCESS,   4'd3,  32'd101,         32'd9,           1'b0, 1'b0, ST_OK},
        '{CMD_ACCESS,   4'd3,  32'd100,         32'd1,           1'b1, 1'b0, ST_OUTSIDE},
        '{CMD_ACCESS,   4'd2,  32'd100,         32'd0,           1'b0, 1'b0, ST_OK},
        '{CMD_ACCESS,   4'd15, 32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 1'b0, ST_OUTSIDE},
        '{CMD_RELEASE,  4'd15, 32'd0,           32'd0,           1'b1, 1'b1, ST_OK}
    };

    logic clk;
    logic rst_n;

    mrac_cfg_if cfg_ch ();
    mrac_req_if req_ch ();
    mrac_rsp_if rsp_ch ();

    memory_region_allocate_and_check_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the region table
    logic [ADDR_W-1:0] mem_limit;
    logic [ADDR_W-1:0] row_lower [TABLE_DEPTH];
    logic [END_W-1:0]  row_upper [TABLE_DEPTH];
    logic [PID_W-1:0]  row_owner [TABLE_DEPTH];
    bit                row_valid [TABLE_DEPTH];

    verdict_t pending_verdicts [$];
    int       mismatch_count;
    int       cycle_count;
    bit       calm;

    // Random draw window of the current phase
    logic [ADDR_W-1:0] win_lo;
    logic [ADDR_W-1:0] win_span;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Verdict of the region table for one request; updates the model
    function automatic verdict_t judge_request(input logic [CMD_W-1:0] cmd,
                                               input logic [PID_W-1:0] pid,
                                               input logic [ADDR_W-1:0] base,
                                               input logic [ADDR_W-1:0] size);
        verdict_t        v;
        logic [END_W-1:0] last;
        int              slot;
        bit              hit;
        int              i;
        v.granted = 1'b0;
        v.status  = ST_OK;
        last = {1'b0, base} + {1'b0, size};
        case (cmd)
            CMD_ALLOC:
            begin
                if (last > {1'b0, mem_limit})
                    v.status = ST_BEYOND;
                else
                begin
                    slot = -1;
                    hit  = 1'b0;
                    for (i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (row_valid[i])
                        begin
                            // touching end points count as overlap
                            if ({1'b0, base} <= row_upper[i] && last >= {1'b0, row_lower[i]})
                                hit = 1'b1;
                        end
                        else if (slot < 0)
                            slot = i;
                    end
                    if (hit)
                        v.status = ST_OVERLAP;
                    else if (slot < 0)
                        v.status = ST_FULL;
                    else
                    begin
                        row_lower[slot] = base;
                        row_upper[slot] = last;
                        row_owner[slot] = pid;
                        row_valid[slot] = 1'b1;
                        v.granted = 1'b1;
                    end
                end
            end
            CMD_ACCESS:
            begin
                v.status = ST_OUTSIDE;
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (row_valid[i] && row_owner[i] == pid && base >= row_lower[i] &&
                        last <= row_upper[i])
                    begin
                        v.granted = 1'b1;
                        v.status  = ST_OK;
                    end
                end
            end
            CMD_RELEASE:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                    if (row_valid[i] && row_owner[i] == pid)
                        row_valid[i] = 1'b0;
                v.granted = 1'b1;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // Present one request item, wait for acceptance, queue its verdict
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                                input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                                input bit typed, input verdict_t typed_v);
        int       gap;
        verdict_t v;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.process_id <= pid;
        req_ch.base       <= base;
        req_ch.size       <= size;
        do @(posedge clk); while (!req_ch.ready);
        v = judge_request(cmd, pid, base, size);
        pending_verdicts.push_back(typed ? typed_v : v);
    endtask

    // Drop valid and wait until every queued verdict has been answered
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
    endtask

    // Memory limit write while the core is idle
    task automatic set_mem_limit(input logic [ADDR_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        mem_limit = value;
    endtask

    // Random request: mostly well-formed traffic inside the window, some noise
    task automatic make_request(output logic [CMD_W-1:0] cmd, output logic [PID_W-1:0] pid,
                                output logic [ADDR_W-1:0] base,
                                output logic [ADDR_W-1:0] size);
        int                pick;
        int                live [$];
        int                i;
        int                j;
        logic [ADDR_W-1:0] hi;
        pick = $urandom_range(0, 99);
        pid  = ($urandom_range(0, 4) == 0) ? PID_W'($urandom_range(0, 15))
                                           : PID_W'($urandom_range(0, 3));
        base = win_lo + $urandom_range(0, win_span);
        size = $urandom_range(0, win_span / 8);
        if (pick < 10)
        begin
            // noise over every field
            cmd  = CMD_W'($urandom_range(0, 3));
            pid  = PID_W'($urandom);
            base = $urandom;
            size = $urandom;
        end
        else if (pick < 50)
            cmd = CMD_ALLOC;
        else if (pick < 82)
        begin
            cmd = CMD_ACCESS;
            for (i = 0; i < TABLE_DEPTH; i++)
                if (row_valid[i])
                    live.push_back(i);
            if (live.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                // aim inside a live region, sometimes one past its end
                j    = live[$urandom_range(0, live.size() - 1)];
                hi   = row_upper[j][ADDR_W-1:0];
                base = row_lower[j] + $urandom_range(0, hi - row_lower[j]);
                size = $urandom_range(0, hi - base);
                if ($urandom_range(0, 3) == 0)
                    size = size + 1;
                if ($urandom_range(0, 4) != 0)
                    pid = row_owner[j];
            end
        end
        else if (pick < 96)
            cmd = CMD_RELEASE;
        else
            cmd = CMD_RESERVED;
    endtask

    // Response side: random stalls before each item
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Response checker
    always @(posedge clk)
    begin : check_rsp
        verdict_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response item: granted %0b status %0d",
                             rsp_ch.granted, rsp_ch.status);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp_ch.granted !== want.granted || rsp_ch.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("response mismatch: expected granted %0b status %0d, got %0b %0d",
                                 want.granted, want.status, rsp_ch.granted, rsp_ch.status);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("FAIL memory_region_allocate_and_check_core");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] limits [PHASE_N];
        int                counts [PHASE_N];
        verdict_t          typed_v;
        int                p;
        int                k;
        int                i;

        calm           = 1'b0;
        mem_limit      = MEM_AVAILABLE_RESET;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            row_lower[i] = '0;
            row_upper[i] = '0;
            row_owner[i] = '0;
            row_valid[i] = 1'b0;
        end
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_ALLOC;
        req_ch.process_id <= '0;
        req_ch.base       <= '0;
        req_ch.size       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < DIR_N; i++)
        begin
            typed_v.granted = DIR_ROWS[i].granted;
            typed_v.status  = DIR_ROWS[i].status;
            send_request(DIR_ROWS[i].cmd, DIR_ROWS[i].pid, DIR_ROWS[i].base,
                         DIR_ROWS[i].size, DIR_ROWS[i].typed, typed_v);
        end

        // Fill the table until an allocation finds no free entry
        for (k = 0; k < 15; k++)
            send_request(CMD_ALLOC, PID_W'(4 + k % 4), 32'd2000 + 4 * k, 32'd2, 1'b0, typed_v);
        for (k = 0; k < 16; k++)
            send_request(CMD_RELEASE, PID_W'(k), 32'd0, 32'd0, 1'b0, typed_v);

        // Random phases over several memory limits
        limits = '{MEM_AVAILABLE_RESET, 32'd0, 32'hFFFF_FFFF, 32'd4096,
                   $urandom, $urandom_range(1, 65535), MEM_AVAILABLE_RESET};
        counts = '{128, 30, 128, 128, 128, 128, 128};
        for (p = 0; p < PHASE_N; p++)
        begin
            set_mem_limit(limits[p]);
            if (mem_limit < 32'd8192)
                win_span = mem_limit;
            else
                win_span = $urandom_range(512, 8192);
            win_lo = $urandom_range(0, mem_limit - win_span);
            for (k = 0; k < counts[p]; k++)
            begin
                if (k % 40 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                // hold off once per phase until the core has answered everything
                if (k == counts[p] / 2)
                    drain();
                make_request(cmd, pid, base, size);
                send_request(cmd, pid, base, size, 1'b0, typed_v);
            end
        end

        drain();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("PASS memory_region_allocate_and_check_core");
        else
            $display("FAIL memory_region_allocate_and_check_core");
        $finish;
    end

endmodule

FILE: memory_region_allocate_and_check_core.f
src/mrac_pkg.sv
src/mrac_if.sv
src/mrac_ram.sv
src/mrac_region_cmp.sv
src/memory_region_allocate_and_check_core.sv
tb/testbench.sv
